// ===== sv/rvpf_pkg.sv =====
// Shared types, constants and color tables for the pixel fetch and color block.
`timescale 1ns / 1ps
package rvpf_pkg;

   typedef enum logic [1:0] {
      MODE_HIRES  = 2'd0,
      MODE_LORES  = 2'd1,
      MODE_DHIRES = 2'd2,
      MODE_DLORES = 2'd3
   } mode_type;

   // register indexes on the csr channel
   localparam logic [1:0] CSR_DISPLAY_MODE   = 2'd0;
   localparam logic [1:0] CSR_PAGE_SELECT    = 2'd1;
   localparam logic [1:0] CSR_ARTIFACT_COLOR = 2'd2;

   localparam int unsigned HIRES_W  = 280;
   localparam int unsigned HIRES_H  = 192;
   localparam int unsigned LORES_W  = 40;
   localparam int unsigned LORES_H  = 48;
   localparam int unsigned DHIRES_W = 560;
   localparam int unsigned DLORES_W = 80;

   localparam logic [15:0] HIRES_BASE0 = 16'h2000;
   localparam logic [15:0] HIRES_BASE1 = 16'h4000;
   localparam logic [15:0] LORES_BASE0 = 16'h0400;
   localparam logic [15:0] LORES_BASE1 = 16'h0800;
   localparam logic [15:0] GROUP_STRIDE = 16'h0028;

   // x / 7 as ((x + 1) * 4681) >> 15, exact for x below 1024
   localparam logic [12:0] DIV7_RECIP = 13'd4681;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // geometry handed from the address unit to the color unit
   typedef struct packed {
      logic       in_range;
      logic [2:0] dot_sel;   // bit of the byte that holds the dot (hi-res modes)
   } geom_type;

   typedef struct packed {
      logic        in_range;
      logic [15:0] video_address;
      logic        aux_bank;
      logic [3:0]  pixel_value;
      rgb_type     color;
   } result_type;

   function automatic rgb_type lores_color(input logic [3:0] idx);
      rgb_type c;
      unique case (idx)
         4'd0:  c = '{8'd0,   8'd0,   8'd0};
         4'd1:  c = '{8'd227, 8'd30,  8'd96};
         4'd2:  c = '{8'd96,  8'd78,  8'd189};
         4'd3:  c = '{8'd255, 8'd68,  8'd253};
         4'd4:  c = '{8'd0,   8'd163, 8'd96};
         4'd5:  c = '{8'd156, 8'd156, 8'd156};
         4'd6:  c = '{8'd20,  8'd207, 8'd253};
         4'd7:  c = '{8'd208, 8'd195, 8'd255};
         4'd8:  c = '{8'd96,  8'd114, 8'd3};
         4'd9:  c = '{8'd255, 8'd106, 8'd60};
         4'd10: c = '{8'd156, 8'd156, 8'd156};
         4'd11: c = '{8'd255, 8'd160, 8'd208};
         4'd12: c = '{8'd20,  8'd245, 8'd60};
         4'd13: c = '{8'd208, 8'd221, 8'd141};
         4'd14: c = '{8'd114, 8'd255, 8'd208};
         default: c = '{8'd255, 8'd255, 8'd255};
      endcase
      return c;
   endfunction

   // index is {color set, x odd}
   function automatic rgb_type artifact_color_of(input logic [1:0] idx);
      rgb_type c;
      unique case (idx)
         2'd0: c = '{8'd255, 8'd0,   8'd255};  // purple
         2'd1: c = '{8'd0,   8'd255, 8'd0};    // green
         2'd2: c = '{8'd0,   8'd128, 8'd255};  // blue
         default: c = '{8'd255, 8'd128, 8'd0}; // orange
      endcase
      return c;
   endfunction

endpackage

// ===== sv/rvpf_addr.sv =====
// Screen geometry: range check, byte column, interleaved address and bank.
`timescale 1ns / 1ps
module rvpf_addr (
   input  rvpf_pkg::mode_type mode,
   input  logic               page,
   input  logic [9:0]         pixel_x,
   input  logic [7:0]         pixel_y,
   output logic [15:0]        video_address,
   output logic               aux_bank,
   output rvpf_pkg::geom_type geom
);
   import rvpf_pkg::*;

   logic [23:0] div_prod;
   logic [7:0]  col;
   logic [10:0] col_x7;
   logic [2:0]  dot;
   logic [15:0] hires_line;
   logic [15:0] lores_row;
   logic [6:0]  row;
   logic        ok;
   logic [15:0] addr;
   logic        aux;

   // byte column and dot position within it
   assign div_prod = 24'({1'b0, pixel_x} + 11'd1) * 24'(DIV7_RECIP);
   assign col      = div_prod[22:15];
   assign col_x7   = 11'({col, 3'b000}) - 11'(col);
   assign dot      = 3'(11'(pixel_x) - col_x7);

   assign hires_line = (page ? HIRES_BASE1 : HIRES_BASE0)
                     + 16'({pixel_y[2:0], 10'b0})
                     + 16'(pixel_y[7:6]) * GROUP_STRIDE
                     + 16'({pixel_y[5:3], 7'b0});

   assign row       = pixel_y[7:1];
   assign lores_row = (page ? LORES_BASE1 : LORES_BASE0)
                    + 16'({row[2:0], 7'b0})
                    + 16'(row[6:3]) * GROUP_STRIDE;

   always_comb begin
      ok   = 1'b0;
      addr = '0;
      aux  = 1'b0;
      unique case (mode)
         MODE_HIRES: begin
            ok   = (pixel_x < 10'(HIRES_W)) && (pixel_y < 8'(HIRES_H));
            addr = hires_line + 16'(col);
         end
         MODE_DHIRES: begin
            ok   = (pixel_x < 10'(DHIRES_W)) && (pixel_y < 8'(HIRES_H));
            aux  = ~col[0];
            addr = hires_line + 16'(col[7:1]);
         end
         MODE_LORES: begin
            ok   = (pixel_x < 10'(LORES_W)) && (pixel_y < 8'(LORES_H));
            addr = lores_row + 16'(pixel_x);
         end
         default: begin
            ok   = (pixel_x < 10'(DLORES_W)) && (pixel_y < 8'(LORES_H));
            aux  = ~pixel_x[0];
            addr = lores_row + 16'(pixel_x[9:1]);
         end
      endcase
   end

   assign video_address = ok ? addr : '0;
   assign aux_bank      = ok & aux;
   assign geom.in_range = ok;
   assign geom.dot_sel  = dot;

endmodule

// ===== sv/rvpf_color.sv =====
// Pixel value extraction and color lookup.
`timescale 1ns / 1ps
module rvpf_color (
   input  rvpf_pkg::mode_type mode,
   input  logic               artifact_on,
   input  rvpf_pkg::geom_type geom,
   input  logic               x_odd,
   input  logic               y_odd,
   input  logic [7:0]         memory_byte,
   output logic [3:0]         pixel_value,
   output rvpf_pkg::rgb_type  color
);
   import rvpf_pkg::*;

   logic    dot;
   logic [3:0] nib;
   rgb_type art;
   rgb_type lo;

   assign dot = memory_byte[geom.dot_sel];
   assign nib = y_odd ? memory_byte[7:4] : memory_byte[3:0];
   assign art = artifact_color_of({memory_byte[7], x_odd});
   assign lo  = lores_color(nib);

   always_comb begin
      pixel_value = '0;
      color       = '0;
      if (geom.in_range) begin
         unique case (mode)
            MODE_HIRES: begin
               pixel_value = {3'b000, dot};
               if (dot) color = artifact_on ? art : rgb_type'{8'd255, 8'd255, 8'd255};
            end
            MODE_DHIRES: begin
               pixel_value = {3'b000, dot};
               if (dot) color = '{8'd255, 8'd255, 8'd255};
            end
            default: begin
               pixel_value = nib;
               color       = lo;
            end
         endcase
      end
   end

endmodule

// ===== sv/retro_video_pixel_fetch_and_color.sv =====
// Top level: pixel fetch address and color, input and result registers, csr.
`timescale 1ns / 1ps
//
//  channel | dir | handshake              | word
//  --------+-----+------------------------+-----------------------------------
//  req     | in  | req_tvalid/req_tready  | pixel coordinate + memory byte
//  rsp     | out | rsp_tvalid/rsp_tready  | range flag, address, bank, color
//  csr     | in  | csr_valid/csr_ready    | register index + write data
//
//  One word per cycle sustained while rsp is not stalled; each word passes
//  the input register, then the result register, before rsp_tvalid rises.
//  reset clears the pipeline valids and the csr registers (hi-res, first
//  page, mono); csr_ready is always high.
//  A stall on rsp holds the result register and backs up through the input
//  register; req_tready drops only when both stages are full and held.
//
module retro_video_pixel_fetch_and_color (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: pixel_x[9:0], pixel_y[17:10], memory_byte[25:18], zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // rsp_tdata: in_range[0], video_address[16:1], aux_bank[17],
   //            pixel_value[21:18], red[29:22], green[37:30], blue[45:38], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import rvpf_pkg::*;

   // configuration registers
   mode_type mode_ff;
   logic     page_ff;
   logic     artifact_ff;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [9:0] x_ff;
   logic [7:0] y_ff;
   logic [7:0] byte_ff;

   // result stage
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type out_in;

   logic     out_open;
   logic     in_open;
   geom_type geom;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_HIRES;
         page_ff     <= 1'b0;
         artifact_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DISPLAY_MODE:   mode_ff     <= mode_type'(csr_wdata[1:0]);
            CSR_PAGE_SELECT:    page_ff     <= csr_wdata[0];
            CSR_ARTIFACT_COLOR: artifact_ff <= csr_wdata[0];
            default: ;  // no register there
         endcase
      end
   end

   // stage moves when the next one is empty or draining
   assign out_open   = ~out_valid_ff | rsp_tready;
   assign in_open    = ~in_valid_ff | out_open;
   assign req_tready = in_open;

   assign in_valid_in  = in_open ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_open ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_open && req_tvalid) begin
         x_ff    <= req_tdata[9:0];
         y_ff    <= req_tdata[17:10];
         byte_ff <= req_tdata[25:18];
      end
      if (out_open && in_valid_ff) begin
         out_ff <= out_in;
      end
   end

   rvpf_addr u_addr (
      .mode          (mode_ff),
      .page          (page_ff),
      .pixel_x       (x_ff),
      .pixel_y       (y_ff),
      .video_address (out_in.video_address),
      .aux_bank      (out_in.aux_bank),
      .geom          (geom)
   );

   rvpf_color u_color (
      .mode        (mode_ff),
      .artifact_on (artifact_ff),
      .geom        (geom),
      .x_odd       (x_ff[0]),
      .y_odd       (y_ff[0]),
      .memory_byte (byte_ff),
      .pixel_value (out_in.pixel_value),
      .color       (out_in.color)
   );

   assign out_in.in_range = geom.in_range;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        out_ff.color.blue,
                        out_ff.color.green,
                        out_ff.color.red,
                        out_ff.pixel_value,
                        out_ff.aux_bank,
                        out_ff.video_address,
                        out_ff.in_range};

endmodule
